// ===== hdl/astm_e1381_link_fsm_unit_assert.svh =====
// ----------------------------------------------------------------------------
// astm link assertion macros
// shared concurrent assertion forms for the link handshake block
// ----------------------------------------------------------------------------
`ifndef ASTM_E1381_LINK_FSM_UNIT_ASSERT_SVH
`define ASTM_E1381_LINK_FSM_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ASTM_LINK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASTM_LINK_IMPLY_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/astm_link_pkg.sv =====
// ----------------------------------------------------------------------------
// astm link package
// codes, constants and shared types of the link handshake block
// ----------------------------------------------------------------------------
package astm_link_pkg;

   // control characters
   localparam logic [7:0] CHAR_EOT = 8'h04;
   localparam logic [7:0] CHAR_ENQ = 8'h05;
   localparam logic [7:0] CHAR_ACK = 8'h06;
   localparam logic [7:0] CHAR_NAK = 8'h15;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   // reset values of the configuration registers
   localparam logic [7:0] RECEIVE_TIMEOUT_RESET = 8'd30;
   localparam logic [7:0] SEND_TIMEOUT_RESET    = 8'd15;
   localparam logic [7:0] RETRY_LIMIT_RESET     = 8'd6;

   // frame sequence runs 1..8
   localparam logic [3:0] SEQ_FIRST = 4'd1;
   localparam logic [3:0] SEQ_LAST  = 4'd8;

   localparam logic [7:0] RETRY_MAX = 8'd255;

   // timeout counter, 9-bit two's complement; all ones is -1 (expired)
   localparam logic [8:0] TICKS_EXPIRED = 9'h1FF;
   localparam logic [8:0] TICKS_ONE     = 9'd1;

   localparam logic [3:0] TARGET_NONE = 4'hF;

   typedef enum logic [3:0] {
      ST_IDLE           = 4'd0,
      ST_AWAKE          = 4'd1,
      ST_WAIT_FRAME     = 4'd2,
      ST_FRAME_RX       = 4'd3,
      ST_TO_SEND        = 4'd4,
      ST_WAIT_ACK       = 4'd5,
      ST_FRAME_READY    = 4'd6,
      ST_WAIT_FRAME_ACK = 4'd7,
      ST_INTERRUPT      = 4'd8
   } link_state_type;

   typedef enum logic [1:0] {
      CSR_RECEIVE_TIMEOUT = 2'd0,
      CSR_SEND_TIMEOUT    = 2'd1,
      CSR_RETRY_LIMIT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] receive_timeout_s;
      logic [7:0] send_timeout_s;
      logic [7:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic       mode;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       frame_pending;
   } req_item_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       send_frame;
      logic       rx_consumed;
      logic [3:0] link_state;
      logic [3:0] frame_sequence;
   } rsp_item_type;

   typedef struct packed {
      link_state_type proto;
      logic [3:0]     target;
      logic [3:0]     seq;
      logic [7:0]     retry;
      logic [8:0]     ticks;
      logic           timed_out;
   } link_ctx_type;

endpackage

// ===== hdl/astm_link_if.sv =====
// ----------------------------------------------------------------------------
// astm link channel interfaces
// valid/ready channels for requests, responses and register writes
// ----------------------------------------------------------------------------
interface astm_link_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic       rx_valid;
   logic [7:0] rx_byte;
   logic       frame_pending;

   modport source (output valid, output mode, output rx_valid, output rx_byte,
                   output frame_pending, input ready);
   modport sink (input valid, input mode, input rx_valid, input rx_byte,
                 input frame_pending, output ready);
endinterface

interface astm_link_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       send_frame;
   logic       rx_consumed;
   logic [3:0] link_state;
   logic [3:0] frame_sequence;

   modport source (output valid, output tx_valid, output tx_byte, output send_frame,
                   output rx_consumed, output link_state, output frame_sequence,
                   input ready);
   modport sink (input valid, input tx_valid, input tx_byte, input send_frame,
                 input rx_consumed, input link_state, input frame_sequence,
                 output ready);
endinterface

interface astm_link_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/astm_link_csr.sv =====
// ----------------------------------------------------------------------------
// astm link register file
// timeout and retry configuration registers
// ----------------------------------------------------------------------------
module astm_link_csr
   import astm_link_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   astm_link_csr_if.sink          csr_chan,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(csr_chan.index))
            CSR_RECEIVE_TIMEOUT: cfg_in.receive_timeout_s = csr_chan.data;
            CSR_SEND_TIMEOUT:    cfg_in.send_timeout_s    = csr_chan.data;
            CSR_RETRY_LIMIT:     cfg_in.retry_limit       = csr_chan.data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.receive_timeout_s <= RECEIVE_TIMEOUT_RESET;
         cfg_ff.send_timeout_s    <= SEND_TIMEOUT_RESET;
         cfg_ff.retry_limit       <= RETRY_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/astm_link_core.sv =====
// ----------------------------------------------------------------------------
// astm link state machine
// link state, sequence, retry, timeout handling: one item per cycle with step_en
// ----------------------------------------------------------------------------
`include "astm_e1381_link_fsm_unit_assert.svh"

module astm_link_core
   import astm_link_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   link_ctx_type ctx_ff;
   link_ctx_type ctx_in;

   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       send_frame;
   logic       rd_byte;
   logic [7:0] retry_bumped;
   logic [8:0] ticks_dec;

   assign retry_bumped = (item.rx_byte == CHAR_NAK && ctx_ff.retry != RETRY_MAX) ?
                         ctx_ff.retry + 8'd1 : ctx_ff.retry;
   assign ticks_dec    = (ctx_ff.ticks != TICKS_EXPIRED) ? ctx_ff.ticks - TICKS_ONE :
                         ctx_ff.ticks;

   // next state
   always_comb begin
      ctx_in = ctx_ff;
      if (item.mode) begin
         ctx_in.ticks = ticks_dec;
         if (ticks_dec == TICKS_EXPIRED) begin
            ctx_in.timed_out = 1'b1;
            if (ctx_ff.target != TARGET_NONE) begin
               ctx_in.proto  = link_state_type'(ctx_ff.target);
               ctx_in.target = TARGET_NONE;
            end
         end
      end else begin
         case (ctx_ff.proto)
            ST_IDLE: begin
               if (item.frame_pending) begin
                  ctx_in.proto = ST_TO_SEND;
               end else if (item.rx_valid && item.rx_byte == CHAR_ENQ) begin
                  ctx_in.proto = ST_AWAKE;
               end
            end
            ST_AWAKE: begin
               ctx_in.seq       = SEQ_FIRST;
               ctx_in.ticks     = {1'b0, cfg.receive_timeout_s};
               ctx_in.timed_out = 1'b0;
               ctx_in.target    = ST_IDLE;
               ctx_in.proto     = ST_WAIT_FRAME;
            end
            ST_WAIT_FRAME: begin
               if (item.rx_valid && item.rx_byte == CHAR_EOT) begin
                  ctx_in.proto = ST_IDLE;
               end else if (item.rx_valid && item.rx_byte == CHAR_LF) begin
                  ctx_in.proto = ST_FRAME_RX;
               end
            end
            ST_FRAME_RX: begin
               ctx_in.seq       = (ctx_ff.seq >= SEQ_LAST) ? SEQ_FIRST : ctx_ff.seq + 4'd1;
               ctx_in.ticks     = {1'b0, cfg.receive_timeout_s};
               ctx_in.timed_out = 1'b0;
               ctx_in.target    = ST_IDLE;
               ctx_in.proto     = ST_WAIT_FRAME;
            end
            ST_TO_SEND: begin
               ctx_in.seq       = SEQ_FIRST;
               ctx_in.ticks     = {1'b0, cfg.send_timeout_s};
               ctx_in.timed_out = 1'b0;
               ctx_in.target    = ST_WAIT_ACK;
               ctx_in.proto     = ST_WAIT_ACK;
            end
            ST_WAIT_ACK: begin
               if (ctx_ff.timed_out) begin
                  ctx_in.proto = ST_IDLE;
               end else if (item.rx_valid) begin
                  if (item.rx_byte == CHAR_ENQ || item.rx_byte == CHAR_NAK) begin
                     ctx_in.proto = ST_IDLE;
                  end else if (item.rx_byte == CHAR_ACK) begin
                     ctx_in.retry = '0;
                     ctx_in.proto = ST_FRAME_READY;
                  end
               end
            end
            ST_FRAME_READY: begin
               if (!item.frame_pending) begin
                  ctx_in.proto = ST_IDLE;
               end else begin
                  ctx_in.ticks     = {1'b0, cfg.send_timeout_s};
                  ctx_in.timed_out = 1'b0;
                  ctx_in.target    = ST_WAIT_FRAME_ACK;
                  ctx_in.proto     = ST_WAIT_FRAME_ACK;
               end
            end
            ST_WAIT_FRAME_ACK: begin
               if (ctx_ff.timed_out) begin
                  ctx_in.proto = ST_IDLE;
               end else if (item.rx_valid) begin
                  if (item.rx_byte == CHAR_ACK) begin
                     ctx_in.retry = '0;
                     ctx_in.proto = ST_FRAME_READY;
                  end else if (item.rx_byte == CHAR_EOT) begin
                     ctx_in.proto = ST_INTERRUPT;
                  end else begin
                     // only a nak counts; other bytes retransmit below the retry limit
                     ctx_in.retry = retry_bumped;
                     ctx_in.proto = (retry_bumped < cfg.retry_limit) ? ST_FRAME_READY :
                                    ST_IDLE;
                  end
               end
            end
            ST_INTERRUPT: ctx_in.proto = ST_IDLE;
            default:      ctx_in.proto = ST_IDLE;
         endcase
      end
   end

   // outputs
   always_comb begin
      tx_valid   = 1'b0;
      tx_byte    = '0;
      send_frame = 1'b0;
      rd_byte    = 1'b0;
      if (!item.mode) begin
         case (ctx_ff.proto)
            ST_IDLE: rd_byte = !item.frame_pending;
            ST_AWAKE, ST_FRAME_RX: begin
               tx_valid = 1'b1;
               tx_byte  = CHAR_ACK;
            end
            ST_WAIT_FRAME: rd_byte = 1'b1;
            ST_TO_SEND: begin
               tx_valid = 1'b1;
               tx_byte  = CHAR_ENQ;
            end
            ST_WAIT_ACK: begin
               if (ctx_ff.timed_out) begin
                  tx_valid = 1'b1;
                  tx_byte  = CHAR_EOT;
               end else begin
                  rd_byte = 1'b1;
               end
            end
            ST_FRAME_READY: begin
               if (!item.frame_pending) begin
                  tx_valid = 1'b1;
                  tx_byte  = CHAR_EOT;
               end else begin
                  send_frame = 1'b1;
               end
            end
            ST_WAIT_FRAME_ACK: begin
               if (ctx_ff.timed_out) begin
                  tx_valid = 1'b1;
                  tx_byte  = CHAR_EOT;
               end else begin
                  rd_byte = 1'b1;
                  if (item.rx_valid && item.rx_byte != CHAR_ACK &&
                      (item.rx_byte == CHAR_EOT || !(retry_bumped < cfg.retry_limit))) begin
                     tx_valid = 1'b1;
                     tx_byte  = CHAR_EOT;
                  end
               end
            end
            ST_INTERRUPT: begin
               tx_valid = 1'b1;
               tx_byte  = CHAR_EOT;
            end
            default: rd_byte = 1'b0;
         endcase
      end
   end

   always_comb begin
      result.tx_valid       = tx_valid;
      result.tx_byte        = tx_byte;
      result.send_frame     = send_frame;
      result.rx_consumed    = rd_byte && item.rx_valid;
      result.link_state     = ctx_in.proto;
      result.frame_sequence = ctx_in.seq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.proto     <= ST_IDLE;
         ctx_ff.target    <= TARGET_NONE;
         ctx_ff.seq       <= '0;
         ctx_ff.retry     <= '0;
         ctx_ff.ticks     <= '0;
         ctx_ff.timed_out <= 1'b0;
      end else if (step_en) begin
         ctx_ff <= ctx_in;
      end
   end

   `ASTM_LINK_IMPLY(a_target_legal, 1'b1, (ctx_ff.target == TARGET_NONE || ctx_ff.target == ST_IDLE || ctx_ff.target == ST_WAIT_ACK || ctx_ff.target == ST_WAIT_FRAME_ACK), "timeout target holds an unexpected state")
   `ASTM_LINK_IMPLY(a_ticks_range, ctx_ff.ticks[8], ctx_ff.ticks == TICKS_EXPIRED, "timeout counter went below minus one")
   `ASTM_LINK_IMPLY_NEXT(a_expiry_flags, step_en && item.mode && (ctx_ff.ticks == '0 || ctx_ff.ticks == TICKS_EXPIRED), ctx_ff.timed_out && ctx_ff.target == TARGET_NONE, "expired tick did not set timeout and clear target")

endmodule

// ===== hdl/astm_e1381_link_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// astm e1381 link handshake unit
// serial link control handshake with one result transaction per request
// ----------------------------------------------------------------------------
// usage:
// - req_chan carries one transaction per poll step (mode 0: optional rx byte
//   and frame-pending flag) or per one-second timer tick (mode 1)
// - rsp_chan returns exactly one transaction per request: control byte to
//   send, send-frame command, rx-consumed mark, link state and sequence number
// - csr_chan writes the receive timeout, send timeout and retry limit
//   (index 0, 1, 2); it is always ready; the user writes it only while idle (not enforced)
// - an accepted request is held in the input register; its response is formed
//   from it and captured in the result register when the item advances
// - throughput: one transaction per cycle unless rsp_chan stalls; the link
//   state update and response are formed in one pass between the two registers
// - reset clears the link state to idle, the sequence and counters to zero,
//   and restores the register defaults (30, 15, 6)
// - when rsp_chan stalls, the held response keeps the output register and one
//   more request still enters the input register; then req_chan.ready drops
// ----------------------------------------------------------------------------
`include "astm_e1381_link_fsm_unit_assert.svh"

module astm_e1381_link_fsm_unit
   import astm_link_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   astm_link_req_if.sink  req_chan,
   astm_link_rsp_if.source rsp_chan,
   astm_link_csr_if.sink  csr_chan
);

   cfg_type      cfg;
   req_item_type req_item;
   rsp_item_type step_result;

   // input register
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;

   // result register
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;

   logic         advance;
   logic         req_take;

   // the state machine steps exactly when an item moves to the result register
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   assign req_item.mode          = req_chan.mode;
   assign req_item.rx_valid      = req_chan.rx_valid;
   assign req_item.rx_byte       = req_chan.rx_byte;
   assign req_item.frame_pending = req_chan.frame_pending;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   astm_link_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   astm_link_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.tx_valid       = out_item_ff.tx_valid;
   assign rsp_chan.tx_byte        = out_item_ff.tx_byte;
   assign rsp_chan.send_frame     = out_item_ff.send_frame;
   assign rsp_chan.rx_consumed    = out_item_ff.rx_consumed;
   assign rsp_chan.link_state     = out_item_ff.link_state;
   assign rsp_chan.frame_sequence = out_item_ff.frame_sequence;

   `ASTM_LINK_IMPLY(a_tx_code, out_valid_ff && out_item_ff.tx_valid, (out_item_ff.tx_byte == CHAR_ACK || out_item_ff.tx_byte == CHAR_ENQ || out_item_ff.tx_byte == CHAR_EOT), "transmit byte is not a control character")
   `ASTM_LINK_IMPLY(a_frame_no_tx, out_valid_ff && out_item_ff.send_frame, !out_item_ff.tx_valid && !out_item_ff.rx_consumed, "send-frame response also sends or consumes a byte")
   `ASTM_LINK_IMPLY(a_seq_range, out_valid_ff, out_item_ff.frame_sequence <= SEQ_LAST, "frame sequence out of range")
   `ASTM_LINK_IMPLY_NEXT(a_rsp_from_input, advance, out_valid_ff, "advanced item did not reach the result register")

endmodule
